FILE: design/hbp_pkg.sv
// shared constants, codes and control types for the huffman bit packer
`default_nettype none
package hbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int PEND_W       = 7;
  localparam int PCNT_W       = 3;
  localparam int ACC_W        = MAX_CODE_LEN + PEND_W;
  localparam int TOT_W        = $clog2(ACC_W + 1);
  localparam int SYM_W        = 8;
  localparam int TAB_DEPTH    = 256;
  localparam int BYTE_W       = 8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EMIT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic mem_wr;
    logic mem_rd;
    logic acc_load;
    logic emit;
    logic fin;
    logic flush_emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic ge8;
    logic last_byte;
    logic pend_nz;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/hbp_ctrl.sv
// controller state machine for the huffman bit packer
`default_nettype none
module hbp_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic [1:0]   in_op,
  output logic              in_tready,
  input  hbp_pkg::sts_t     sts,
  output hbp_pkg::cmd_t     cmd
);

  hbp_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign in_tready = (state_r == hbp_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hbp_pkg::S_IDLE: begin
        if (accept) begin
          case (hbp_pkg::op_t'(in_op))
            hbp_pkg::OP_ENCODE: state_nxt = hbp_pkg::S_LOOKUP;
            hbp_pkg::OP_FLUSH:  state_nxt = hbp_pkg::S_FLUSH;
            default:            state_nxt = hbp_pkg::S_IDLE;
          endcase
        end
      end
      hbp_pkg::S_LOOKUP: state_nxt = hbp_pkg::S_EMIT;
      hbp_pkg::S_EMIT: begin
        if (!sts.ge8) begin
          state_nxt = hbp_pkg::S_IDLE;
        end else if (sts.out_free && sts.last_byte) begin
          state_nxt = hbp_pkg::S_IDLE;
        end
      end
      hbp_pkg::S_FLUSH: begin
        if (!sts.pend_nz || sts.out_free) begin
          state_nxt = hbp_pkg::S_IDLE;
        end
      end
      default: state_nxt = hbp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      hbp_pkg::S_IDLE: begin
        if (accept) begin
          case (hbp_pkg::op_t'(in_op))
            hbp_pkg::OP_LOAD:   cmd.mem_wr = 1'b1;
            hbp_pkg::OP_ENCODE: cmd.mem_rd = 1'b1;
            default:            cmd = '0;
          endcase
        end
      end
      hbp_pkg::S_LOOKUP: cmd.acc_load = 1'b1;
      hbp_pkg::S_EMIT: begin
        if (!sts.ge8) begin
          cmd.fin = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.fin  = sts.last_byte;
        end
      end
      hbp_pkg::S_FLUSH: begin
        if (!sts.pend_nz) begin
          cmd.clear = 1'b1;
        end else if (sts.out_free) begin
          cmd.flush_emit = 1'b1;
          cmd.clear      = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/hbp_datapath.sv
// code table, bit accumulator and output register of the huffman bit packer
`default_nettype none
module hbp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [hbp_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic [hbp_pkg::CODE_W-1:0]    in_code_word,
  input  wire logic [hbp_pkg::LEN_W-1:0]     in_code_len,
  input  hbp_pkg::cmd_t                      cmd,
  output hbp_pkg::sts_t                      sts,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [hbp_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_last
);

  localparam int ENT_W = hbp_pkg::LEN_W + hbp_pkg::CODE_W;

  logic [ENT_W-1:0] mem [hbp_pkg::TAB_DEPTH];
  logic [ENT_W-1:0] rd_r;

  logic [hbp_pkg::LEN_W-1:0]  len_clamp;
  logic [hbp_pkg::LEN_W-1:0]  rd_len;
  logic [hbp_pkg::CODE_W-1:0] rd_code;

  logic [hbp_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [hbp_pkg::TOT_W-1:0]  total_r, total_nxt;
  logic [hbp_pkg::TOT_W-1:0]  tot_m8, rem;
  logic [hbp_pkg::PEND_W-1:0] pbits_r, pbits_nxt;
  logic [hbp_pkg::PCNT_W-1:0] pcount_r, pcount_nxt;

  logic                       out_valid_r;
  logic [hbp_pkg::BYTE_W-1:0] out_data_r;
  logic                       out_last_r;
  logic [hbp_pkg::BYTE_W-1:0] emit_byte, flush_byte;

  assign len_clamp = (in_code_len > hbp_pkg::LEN_W'(hbp_pkg::MAX_CODE_LEN))
                   ? hbp_pkg::LEN_W'(hbp_pkg::MAX_CODE_LEN) : in_code_len;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[in_symbol] <= {len_clamp, in_code_word};
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[in_symbol];
    end
  end

  assign rd_len  = rd_r[ENT_W-1 -: hbp_pkg::LEN_W];
  assign rd_code = rd_r[hbp_pkg::CODE_W-1:0];

  // pending bits go ahead of the new code bits
  assign acc_nxt = (hbp_pkg::ACC_W'(pbits_r) << rd_len)
                 | (hbp_pkg::ACC_W'(rd_code) & ~({hbp_pkg::ACC_W{1'b1}} << rd_len));
  assign total_nxt = hbp_pkg::TOT_W'(pcount_r) + hbp_pkg::TOT_W'(rd_len);

  assign tot_m8    = total_r - hbp_pkg::TOT_W'(8);
  assign emit_byte = hbp_pkg::BYTE_W'(acc_r >> tot_m8);
  assign rem       = cmd.emit ? tot_m8 : total_r;
  assign pbits_nxt = acc_r[hbp_pkg::PEND_W-1:0] & ~({hbp_pkg::PEND_W{1'b1}} << rem);
  assign pcount_nxt = rem[hbp_pkg::PCNT_W-1:0];

  // left-justify leftover bits, zero padding below
  assign flush_byte = hbp_pkg::BYTE_W'({1'b0, pbits_r} << (4'd8 - {1'b0, pcount_r}));

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc_r   <= acc_nxt;
      total_r <= total_nxt;
    end else if (cmd.emit) begin
      total_r <= tot_m8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbits_r  <= '0;
      pcount_r <= '0;
    end else if (cmd.fin) begin
      pbits_r  <= pbits_nxt;
      pcount_r <= pcount_nxt;
    end else if (cmd.clear) begin
      pbits_r  <= '0;
      pcount_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.flush_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= emit_byte;
      out_last_r <= (tot_m8 < hbp_pkg::TOT_W'(8));
    end else if (cmd.flush_emit) begin
      out_data_r <= flush_byte;
      out_last_r <= 1'b1;
    end
  end

  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.ge8       = (total_r >= hbp_pkg::TOT_W'(8));
  assign sts.last_byte = (total_r < hbp_pkg::TOT_W'(16));
  assign sts.pend_nz   = (pcount_r != '0);

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_data_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

FILE: design/huffman_bit_packer_top.sv
// top level of the huffman bit packer: static huffman encoder
//
//  channel | dir | handshake                 | payload
//  in      | in  | in_tvalid / in_tready     | in_tuser op, in_tdata symbol/code/length
//  out     | out | out_tvalid / out_tready   | out_tdata byte, out_tlast
//
// a load writes the table, a flush emits leftover bits as one padded byte, and an encode
// passes the registered table read and then the one-byte output register
// one item is in work at a time; a new beat is taken while the last byte still waits
// rst_n is synchronous; the code table is not cleared and holds garbage until loaded
// a stalled output holds the emit loop until out_tready returns
`default_nettype none
module huffman_bit_packer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // symbol[7:0], code_word[39:8], code_len[45:40]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic             out_tlast
);

  hbp_pkg::cmd_t cmd;
  hbp_pkg::sts_t sts;

  hbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hbp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_symbol      (in_tdata[7:0]),
    .in_code_word   (in_tdata[39:8]),
    .in_code_len    (in_tdata[45:40]),
    .cmd            (cmd),
    .sts            (sts),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_byte       (out_tdata),
    .out_last       (out_tlast)
  );

endmodule
`default_nettype wire

FILE: design/hbp_chk.sv
// port-level assertion checker for the huffman bit packer, bound to the top level
`default_nettype none
module hbp_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a table load never produces a byte
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == hbp_pkg::OP_LOAD) && !out_tvalid |=> !out_tvalid)
    else $error("load beat produced output");

endmodule

bind huffman_bit_packer_top hbp_chk u_hbp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

FILE: dv/hbp_stream_checker.sv
// stream checker for the huffman bit packer: predicts packed bytes and compares them
module hbp_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // symbol[7:0], code_word[39:8], code_len[45:40]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // out_byte[7:0]
  input  logic        out_tlast,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [hbp_pkg::BYTE_W-1:0] data;
    logic                       last;
  } coded_byte_t;

  logic [hbp_pkg::CODE_W-1:0] code_mem [hbp_pkg::TAB_DEPTH];
  logic [hbp_pkg::LEN_W-1:0]  len_mem  [hbp_pkg::TAB_DEPTH];
  logic [hbp_pkg::PEND_W-1:0] left_bits  = '0;
  logic [hbp_pkg::PCNT_W-1:0] left_count = '0;
  coded_byte_t                coded_byte_q [$];
  int                         errors = 0;

  function automatic void pack_symbol(input logic [1:0] op, input logic [47:0] beat);
    logic [hbp_pkg::SYM_W-1:0]  sym;
    logic [hbp_pkg::CODE_W-1:0] word;
    logic [hbp_pkg::LEN_W-1:0]  len;
    logic [63:0]                acc;
    int                         total;
    sym  = beat[7:0];
    word = beat[39:8];
    len  = beat[45:40];
    case (op)
      hbp_pkg::OP_LOAD: begin
        code_mem[sym] = word;
        len_mem[sym]  = (len > hbp_pkg::MAX_CODE_LEN)
                      ? hbp_pkg::LEN_W'(hbp_pkg::MAX_CODE_LEN) : len;
      end
      hbp_pkg::OP_ENCODE: begin
        len   = len_mem[sym];
        acc   = (64'(left_bits) << len) | (64'(code_mem[sym]) & ((64'd1 << len) - 64'd1));
        total = int'(left_count) + int'(len);
        while (total >= 8) begin
          total -= 8;
          coded_byte_q.push_back(coded_byte_t'{data: 8'(acc >> total), last: total < 8});
        end
        left_bits  = hbp_pkg::PEND_W'(acc & ((64'd1 << total) - 64'd1));
        left_count = hbp_pkg::PCNT_W'(total);
      end
      hbp_pkg::OP_FLUSH: begin
        if (left_count != 0)
          coded_byte_q.push_back(coded_byte_t'{
            data: 8'(16'(left_bits) << (8 - int'(left_count))), last: 1'b1});
        left_bits  = '0;
        left_count = '0;
      end
      default: ;  // unused code, ignored by the block
    endcase
  endfunction

  function automatic void check_byte(input logic [7:0] data, input logic last);
    coded_byte_t want;
    if (coded_byte_q.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
               $time, data, last);
      errors++;
      return;
    end
    want = coded_byte_q.pop_front();
    if (data !== want.data) begin
      $display("%0t: out byte mismatch, expected %02h actual %02h", $time, want.data, data);
      errors++;
    end
    if (last !== want.last) begin
      $display("%0t: out last mismatch, expected %0b actual %0b", $time, want.last, last);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pack_symbol(in_tuser, in_tdata);
      if (out_tvalid && out_tready)
        check_byte(out_tdata, out_tlast);
    end
    fail_count  <= errors;
    outstanding <= coded_byte_q.size();
  end

endmodule

FILE: dv/tb_huffman_bit_packer_top.sv
// testbench top for the huffman bit packer: stimulus, idling and verdict
module tb_huffman_bit_packer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         NUM_RANDOM  = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // symbol[7:0], code_word[39:8], code_len[45:40]
  logic [1:0]  in_tuser;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // out_byte[7:0]
  logic        out_tlast;

  int fail_count;
  int outstanding;
  int idle_pct = 29;
  int quiet_cycles = 0;
  bit loaded_sym [hbp_pkg::TAB_DEPTH];
  int loaded_list [$];

  huffman_bit_packer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  hbp_stream_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // counts cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [7:0] sym,
                           input logic [31:0] word, input logic [5:0] len);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, len, word, sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == hbp_pkg::OP_LOAD && !loaded_sym[sym]) begin
      loaded_sym[sym] = 1'b1;
      loaded_list.push_back(int'(sym));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int          pick;
    logic [5:0]  len;
    logic [7:0]  sym;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // table extremes: zero length, full length, stray bits, clamped length
    send_beat(hbp_pkg::OP_LOAD, 8'd0,   32'hFFFF_FFFF, 6'd0);
    send_beat(hbp_pkg::OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    send_beat(hbp_pkg::OP_LOAD, 8'd1,   32'hFFFF_FFFE, 6'd1);
    send_beat(hbp_pkg::OP_LOAD, 8'd2,   32'hA5A5_5A5A, 6'd63);
    send_beat(hbp_pkg::OP_LOAD, 8'd3,   32'h8000_0055, 6'd7);
    send_beat(hbp_pkg::OP_LOAD, 8'd4,   32'h0000_0000, 6'd8);
    send_beat(hbp_pkg::OP_LOAD, 8'd5,   32'h0000_0001, 6'd33);
    send_beat(hbp_pkg::OP_ENCODE, 8'd255, 32'h0, 6'd0);
    send_beat(hbp_pkg::OP_ENCODE, 8'd3,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_ENCODE, 8'd255, 32'h0, 6'd0);
    send_beat(hbp_pkg::OP_FLUSH,  8'd0,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_FLUSH,  8'd0,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_ENCODE, 8'd0,   32'h0, 6'd0);
    send_beat(OP_UNUSED,          8'hFF,  32'hFFFF_FFFF, 6'h3F);
    send_beat(hbp_pkg::OP_ENCODE, 8'd1,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_ENCODE, 8'd1,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_ENCODE, 8'd1,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_FLUSH,  8'd0,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_ENCODE, 8'd4,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_ENCODE, 8'd2,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_ENCODE, 8'd3,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_ENCODE, 8'd5,   32'h0, 6'd0);
    send_beat(hbp_pkg::OP_FLUSH,  8'd0,   32'h0, 6'd0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      idle_pct = (i >= 120 && i < 200) ? 0 : 29;
      if (i == 220)
        wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        case ($urandom_range(0, 9))
          0, 1:    len = 6'($urandom_range(0, 63));
          2:       len = 6'($urandom_range(24, 32));
          default: len = 6'($urandom_range(1, 12));
        endcase
        send_beat(hbp_pkg::OP_LOAD, 8'($urandom_range(0, 255)), $urandom, len);
      end else if (pick < 85) begin
        sym = 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        send_beat(hbp_pkg::OP_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)));
      end else if (pick < 95) begin
        send_beat(hbp_pkg::OP_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                  6'($urandom_range(0, 63)));
      end else begin
        send_beat(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                  6'($urandom_range(0, 63)));
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: huffman_bit_packer_top.f
design/hbp_pkg.sv
design/hbp_ctrl.sv
design/hbp_datapath.sv
design/huffman_bit_packer_top.sv
design/hbp_chk.sv
dv/hbp_stream_checker.sv
dv/tb_huffman_bit_packer_top.sv
